/* sv/esps_pkg.sv */
`timescale 1ns / 1ps

package esps_pkg;

	// operand widths of the shared shift-subtract divider
	localparam int unsigned DvdW   = 37;  // widest dividend: cache unit count
	localparam int unsigned DvsW   = 19;  // widest divisor: trial divisor below 2^19
	localparam int unsigned CntW   = 6;
	localparam int unsigned SqW    = 38;  // square of the trial divisor
	localparam int unsigned EpochW = 32;
	localparam int unsigned LenW   = 16;
	localparam int unsigned SizeW  = 43;
	localparam int unsigned SumW   = 50;  // unit count before saturation

	localparam logic [CntW-1:0] EpochSteps = CntW'(EpochW - 1);
	localparam logic [CntW-1:0] ModSteps   = CntW'(DvdW - 1);

	localparam logic [LenW-1:0] EpochLenReset = 16'd7500;

	localparam logic [SumW-1:0] DatasetBase = SumW'(64'd1 << 23);
	localparam logic [SumW-1:0] CacheBase   = SumW'(64'd1 << 19);
	localparam logic [SumW-1:0] DatasetCap  = SumW'((64'd1 << 36) - 64'd1);
	localparam logic [SumW-1:0] CacheCap    = SumW'((64'd1 << 37) - 64'd1);

	localparam logic OpDataset = 1'b0;
	localparam logic OpCache   = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_FORM  = 6'b000100,
		ST_CHECK = 6'b001000,
		ST_MOD   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

/* sv/epoch_size_prime_search.sv */
`timescale 1ns / 1ps

// Epoch size search: dataset or cache size for the epoch of a block height.
// Input transfer: s_axis_tdata carries the block height, s_axis_tuser the
// opcode (0 dataset in 128-byte units, 1 cache in 64-byte units). Output
// transfer: size in bytes and epoch number in m_axis_tdata.
// cfg_wen/cfg_wdata set the epoch length; write it only while the block is idle.
// One item at a time: s_axis_tready is high only while idle. All arithmetic
// runs through one restoring shift-subtract divider, one bit per cycle: first
// the epoch division, then for each candidate unit count, counting down, a
// trial division by each odd divisor (3, 5, 7, ... up to the square root);
// even candidates are dropped at once.
// The result waits in an output register; the next item is taken while it
// waits, and a finished search holds until the register is free.
// Reset clears the control state, empties the output and sets the epoch
// length to 7500.
module epoch_size_prime_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // height
	input  logic [0:0]  s_axis_tuser,   // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata    // size_bytes[42:0], epoch_number[74:43], zeros
);

	localparam int unsigned DvdW   = esps_pkg::DvdW;
	localparam int unsigned DvsW   = esps_pkg::DvsW;
	localparam int unsigned CntW   = esps_pkg::CntW;
	localparam int unsigned SqW    = esps_pkg::SqW;
	localparam int unsigned EpochW = esps_pkg::EpochW;
	localparam int unsigned LenW   = esps_pkg::LenW;
	localparam int unsigned SizeW  = esps_pkg::SizeW;
	localparam int unsigned SumW   = esps_pkg::SumW;

	esps_pkg::state_t state_q;

	logic [LenW-1:0]   len_q;
	logic              op_q;
	logic [EpochW-1:0] epoch_q;
	logic [DvdW-1:0]   n_q;
	logic [DvsW-1:0]   d_q;
	logic [SqW-1:0]    dsq_q;
	logic [DvdW-1:0]   dvd_q;
	logic [DvsW-1:0]   dvs_q;
	logic [DvsW-1:0]   rem_q;
	logic [CntW-1:0]   cnt_q;
	logic              out_valid_q;
	logic [79:0]       out_data_q;

	// shared divider step
	logic [DvsW:0]     rem_sh;
	logic              ge;
	logic [DvsW-1:0]   rem_nx;
	logic [DvdW-1:0]   dvd_nx;

	logic [SumW-1:0]   units;
	logic [SumW-1:0]   cap;
	logic [SizeW-1:0]  size;
	logic              accept_in;
	logic              out_free;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DvdW-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
		dvd_nx = {dvd_q[DvdW-2:0], ge};
	end

	always_comb begin
		if (op_q == esps_pkg::OpDataset) begin
			units = (SumW'(epoch_q) << 16) + esps_pkg::DatasetBase - SumW'(1);
			cap   = esps_pkg::DatasetCap;
		end else begin
			units = (SumW'(epoch_q) << 12) + esps_pkg::CacheBase - SumW'(1);
			cap   = esps_pkg::CacheCap;
		end
	end

	assign size = (op_q == esps_pkg::OpDataset) ? SizeW'({n_q, 7'b0}) : SizeW'({n_q, 6'b0});

	assign s_axis_tready = (state_q == esps_pkg::ST_IDLE);
	assign accept_in     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= esps_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			len_q       <= esps_pkg::EpochLenReset;
		end else begin
			if (cfg_wen) begin
				len_q <= cfg_wdata;
			end
			if (state_q == esps_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				esps_pkg::ST_IDLE: begin
					if (accept_in) state_q <= esps_pkg::ST_DIV;
				end
				esps_pkg::ST_DIV: begin
					if (cnt_q == esps_pkg::EpochSteps) state_q <= esps_pkg::ST_FORM;
				end
				esps_pkg::ST_FORM: begin
					state_q <= esps_pkg::ST_CHECK;
				end
				esps_pkg::ST_CHECK: begin
					if (n_q < DvdW'(4) || (n_q[0] && dsq_q > SqW'(n_q))) begin
						state_q <= esps_pkg::ST_DONE;
					end else if (n_q[0]) begin
						state_q <= esps_pkg::ST_MOD;
					end
				end
				esps_pkg::ST_MOD: begin
					if (cnt_q == esps_pkg::ModSteps) state_q <= esps_pkg::ST_CHECK;
				end
				esps_pkg::ST_DONE: begin
					if (out_free) state_q <= esps_pkg::ST_IDLE;
				end
				default: state_q <= esps_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			esps_pkg::ST_IDLE: begin
				if (accept_in) begin
					op_q  <= s_axis_tuser[0];
					dvd_q <= {s_axis_tdata, (DvdW - EpochW)'(0)};
					dvs_q <= DvsW'(len_q);
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			esps_pkg::ST_DIV: begin
				dvd_q <= dvd_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == esps_pkg::EpochSteps) epoch_q <= dvd_nx[EpochW-1:0];
			end
			esps_pkg::ST_FORM: begin
				n_q   <= (units > cap) ? DvdW'(cap) : DvdW'(units);
				d_q   <= DvsW'(3);
				dsq_q <= SqW'(9);
			end
			esps_pkg::ST_CHECK: begin
				if (n_q >= DvdW'(4)) begin
					if (!n_q[0]) begin
						// even candidate: drop it at once
						n_q   <= n_q - DvdW'(1);
						d_q   <= DvsW'(3);
						dsq_q <= SqW'(9);
					end else if (dsq_q <= SqW'(n_q)) begin
						dvd_q <= n_q;
						dvs_q <= d_q;
						rem_q <= '0;
						cnt_q <= '0;
					end
				end
			end
			esps_pkg::ST_MOD: begin
				dvd_q <= dvd_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == esps_pkg::ModSteps) begin
					if (rem_nx == '0) begin
						n_q   <= n_q - DvdW'(1);
						d_q   <= DvsW'(3);
						dsq_q <= SqW'(9);
					end else begin
						// advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
						d_q   <= d_q + DvsW'(2);
						dsq_q <= dsq_q + SqW'({d_q, 2'b00}) + SqW'(4);
					end
				end
			end
			esps_pkg::ST_DONE: begin
				if (out_free) out_data_q <= {5'b0, epoch_q, size};
			end
			default: ;
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> (state_q == esps_pkg::ST_DIV) && !s_axis_tready)
		else $error("item accepted but divider not started");

	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == esps_pkg::ST_MOD) |-> (dsq_q == SqW'(SqW'(d_q) * SqW'(d_q))))
		else $error("trial divisor square out of step");

	a_divisor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == esps_pkg::ST_MOD) |-> (cnt_q <= esps_pkg::ModSteps) && d_q[0])
		else $error("modulo step count or divisor parity wrong");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == esps_pkg::ST_DONE) && out_free |=> m_axis_tvalid
			&& (state_q == esps_pkg::ST_IDLE))
		else $error("finished result not presented");

endmodule
